FILE: rtl/core/rbdq_pkg.sv
package rbdq_pkg;

	localparam int DEPTH          = 16;
	localparam int WORD_BITS      = 32;
	localparam int IDX_BITS       = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_BITS       = $clog2(DEPTH + 1);
	localparam int VALUE_BITS     = 32;
	localparam int REQ_BITS       = 3;
	localparam int STATUS_BITS    = 2;
	localparam int ITEM_CNT_BITS  = 5;

	typedef logic [WORD_BITS-1:0] word_t;
	typedef logic [IDX_BITS-1:0]  idx_t;
	typedef logic [CNT_BITS-1:0]  cnt_t;

	// request codes
	localparam logic [REQ_BITS-1:0] REQ_PUSH_BACK  = 3'd0;
	localparam logic [REQ_BITS-1:0] REQ_PUSH_FRONT = 3'd1;
	localparam logic [REQ_BITS-1:0] REQ_POP_FRONT  = 3'd2;
	localparam logic [REQ_BITS-1:0] REQ_POP_BACK   = 3'd3;
	localparam logic [REQ_BITS-1:0] REQ_PEEK_FRONT = 3'd4;
	localparam logic [REQ_BITS-1:0] REQ_CLEAR      = 3'd5;

	// status codes
	localparam logic [STATUS_BITS-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_BITS-1:0] ST_EMPTY = 2'd1;
	localparam logic [STATUS_BITS-1:0] ST_FULL  = 2'd2;

	typedef struct packed {
		logic [REQ_BITS-1:0]   req_type;
		logic signed [VALUE_BITS-1:0] push_value;
	} req_t;

	typedef struct packed {
		logic signed [VALUE_BITS-1:0] result_value;
		logic [STATUS_BITS-1:0]       status;
		logic [ITEM_CNT_BITS-1:0]     item_count;
	} rsp_t;

	// which store slot the current command touches
	typedef enum logic [1:0] {
		ADDR_HEAD,
		ADDR_HEAD_PREV,
		ADDR_TAIL,
		ADDR_TAIL_PREV
	} addr_sel_t;

	typedef struct packed {
		logic                   exec;
		logic                   wr_en;
		logic                   rd_en;
		addr_sel_t              addr_sel;
		logic                   head_next;
		logic                   head_prev;
		logic                   tail_next;
		logic                   tail_prev;
		logic                   cnt_inc;
		logic                   cnt_dec;
		logic                   clear;
		logic [STATUS_BITS-1:0] status;
	} cmd_t;

	typedef struct packed {
		logic empty;
		logic full;
	} dp_status_t;

	function automatic idx_t idx_next(idx_t i);
		idx_t r;
		if (i == idx_t'(DEPTH - 1)) r = '0;
		else r = i + idx_t'(1);
		return r;
	endfunction

	function automatic idx_t idx_prev(idx_t i);
		idx_t r;
		if (i == '0) r = idx_t'(DEPTH - 1);
		else r = i - idx_t'(1);
		return r;
	endfunction

endpackage

FILE: rtl/core/rbdq_ctrl.sv
module rbdq_ctrl (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [rbdq_pkg::REQ_BITS-1:0] req_type,
	input  rbdq_pkg::dp_status_t        dp_status,
	output rbdq_pkg::cmd_t              cmd,
	output logic                        busy,
	output logic                        done
);

	typedef enum logic {
		S_IDLE,
		S_RESULT
	} state_t;

	state_t state_q;
	logic   busy_q;
	logic   done_q;
	logic   accept;

	assign accept = start && (state_q == S_IDLE);

	always_comb begin
		cmd          = '0;
		cmd.addr_sel = rbdq_pkg::ADDR_HEAD;
		cmd.status   = rbdq_pkg::ST_OK;
		cmd.exec     = accept;
		if (accept) begin
			case (req_type)
				rbdq_pkg::REQ_PUSH_BACK: begin
					if (dp_status.full) begin
						cmd.status = rbdq_pkg::ST_FULL;
					end else begin
						cmd.wr_en     = 1'b1;
						cmd.addr_sel  = rbdq_pkg::ADDR_TAIL;
						cmd.tail_next = 1'b1;
						cmd.cnt_inc   = 1'b1;
					end
				end
				rbdq_pkg::REQ_PUSH_FRONT: begin
					if (dp_status.full) begin
						cmd.status = rbdq_pkg::ST_FULL;
					end else begin
						cmd.wr_en     = 1'b1;
						cmd.addr_sel  = rbdq_pkg::ADDR_HEAD_PREV;
						cmd.head_prev = 1'b1;
						cmd.cnt_inc   = 1'b1;
					end
				end
				rbdq_pkg::REQ_POP_FRONT: begin
					if (dp_status.empty) begin
						cmd.status = rbdq_pkg::ST_EMPTY;
					end else begin
						cmd.rd_en     = 1'b1;
						cmd.addr_sel  = rbdq_pkg::ADDR_HEAD;
						cmd.head_next = 1'b1;
						cmd.cnt_dec   = 1'b1;
					end
				end
				rbdq_pkg::REQ_POP_BACK: begin
					if (dp_status.empty) begin
						cmd.status = rbdq_pkg::ST_EMPTY;
					end else begin
						cmd.rd_en     = 1'b1;
						cmd.addr_sel  = rbdq_pkg::ADDR_TAIL_PREV;
						cmd.tail_prev = 1'b1;
						cmd.cnt_dec   = 1'b1;
					end
				end
				rbdq_pkg::REQ_PEEK_FRONT: begin
					if (dp_status.empty) begin
						cmd.status = rbdq_pkg::ST_EMPTY;
					end else begin
						cmd.rd_en    = 1'b1;
						cmd.addr_sel = rbdq_pkg::ADDR_HEAD;
					end
				end
				rbdq_pkg::REQ_CLEAR: begin
					cmd.clear = 1'b1;
				end
				default: begin
					// unused codes do nothing
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_RESULT;
						busy_q  <= 1'b1;
						done_q  <= 1'b1;
					end
				end
				S_RESULT: begin
					state_q <= S_IDLE;
					busy_q  <= 1'b0;
					done_q  <= 1'b0;
				end
				default: begin
					state_q <= S_IDLE;
					busy_q  <= 1'b0;
					done_q  <= 1'b0;
				end
			endcase
		end
	end

	assign busy = busy_q;
	assign done = done_q;

endmodule

FILE: rtl/core/rbdq_datapath.sv
module rbdq_datapath (
	input  logic                 clk,
	input  logic                 arst_n,
	input  rbdq_pkg::cmd_t       cmd,
	input  rbdq_pkg::word_t      wr_word,
	output rbdq_pkg::dp_status_t dp_status,
	output rbdq_pkg::rsp_t       rsp
);

	rbdq_pkg::word_t mem [rbdq_pkg::DEPTH];

	rbdq_pkg::idx_t head_q;
	rbdq_pkg::idx_t tail_q;
	rbdq_pkg::cnt_t count_q;
	rbdq_pkg::word_t rd_data_q;
	logic           rd_valid_q;
	logic [rbdq_pkg::STATUS_BITS-1:0] status_q;
	rbdq_pkg::idx_t addr;

	always_comb begin
		case (cmd.addr_sel)
			rbdq_pkg::ADDR_HEAD:      addr = head_q;
			rbdq_pkg::ADDR_HEAD_PREV: addr = rbdq_pkg::idx_prev(head_q);
			rbdq_pkg::ADDR_TAIL:      addr = tail_q;
			rbdq_pkg::ADDR_TAIL_PREV: addr = rbdq_pkg::idx_prev(tail_q);
			default:                  addr = head_q;
		endcase
	end

	assign dp_status.empty = (count_q == '0);
	assign dp_status.full  = (count_q == rbdq_pkg::cnt_t'(rbdq_pkg::DEPTH));

	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			mem[addr] <= wr_word;
		end
		if (cmd.rd_en) begin
			rd_data_q <= mem[addr];
		end
		if (cmd.exec) begin
			status_q <= cmd.status;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q     <= '0;
			tail_q     <= '0;
			count_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (cmd.exec) begin
				rd_valid_q <= cmd.rd_en;
			end
			if (cmd.clear) begin
				head_q  <= '0;
				tail_q  <= '0;
				count_q <= '0;
			end else begin
				if (cmd.head_next) head_q <= rbdq_pkg::idx_next(head_q);
				if (cmd.head_prev) head_q <= rbdq_pkg::idx_prev(head_q);
				if (cmd.tail_next) tail_q <= rbdq_pkg::idx_next(tail_q);
				if (cmd.tail_prev) tail_q <= rbdq_pkg::idx_prev(tail_q);
				if (cmd.cnt_inc)   count_q <= count_q + rbdq_pkg::cnt_t'(1);
				if (cmd.cnt_dec)   count_q <= count_q - rbdq_pkg::cnt_t'(1);
			end
		end
	end

	// the store holds words as wide as the result field; read them as signed
	assign rsp.result_value = rd_valid_q
		? rbdq_pkg::VALUE_BITS'($signed(rd_data_q)) : '0;
	assign rsp.status       = status_q;
	assign rsp.item_count   = rbdq_pkg::ITEM_CNT_BITS'(count_q);

endmodule

FILE: rtl/core/ring_buffer_deque_core.sv
// Channel   Handshake        Payload            Notes
// request   start / busy     req  (req_t)       beat taken when start && !busy
// result    done (strobe)    rsp  (rsp_t)       valid for the single done cycle
//
// The accept edge of a request does the pointer update and the store write or
// registered read; the next cycle shows the result with done. busy is high in
// that result cycle, so no new beat is taken before the result has been shown.
// Reset (arst_n low) empties the queue; store contents are not cleared.
// The receiver cannot stall; a result is lost if not sampled on its done cycle.
module ring_buffer_deque_core (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  rbdq_pkg::req_t   req,
	output logic             done,
	output rbdq_pkg::rsp_t   rsp
);

	rbdq_pkg::cmd_t       cmd;
	rbdq_pkg::dp_status_t dp_status;

	rbdq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.req_type  (req.req_type),
		.dp_status (dp_status),
		.cmd       (cmd),
		.busy      (busy),
		.done      (done)
	);

	rbdq_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.wr_word   (rbdq_pkg::word_t'(req.push_value)),
		.dp_status (dp_status),
		.rsp       (rsp)
	);

endmodule

FILE: rtl/core/rbdq_checker.sv
module rbdq_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           start,
	input logic           busy,
	input logic           done,
	input rbdq_pkg::rsp_t rsp
);

	// every accepted beat yields its result strobe in the next cycle
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> done)
		else $error("no result after accepted request");

	// no new beat can be taken while a result is on the ports
	a_busy_on_result: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy)
		else $error("result shown while request port open");

	a_single_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe longer than one cycle");

	a_fail_no_value: assert property (@(posedge clk) disable iff (!arst_n)
		done && (rsp.status == rbdq_pkg::ST_EMPTY || rsp.status == rbdq_pkg::ST_FULL)
		|-> rsp.result_value == '0)
		else $error("failed request returned a value");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> rsp.item_count <= rbdq_pkg::ITEM_CNT_BITS'(rbdq_pkg::DEPTH))
		else $error("item count beyond depth");

endmodule

bind ring_buffer_deque_core rbdq_checker u_rbdq_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.rsp    (rsp)
);

FILE: tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
	import rbdq_pkg::*;

	localparam int  N_RANDOM    = 1800;
	localparam int  CYCLE_LIMIT = 200000;
	localparam logic [REQ_BITS-1:0] REQ_NOP_6 = 3'd6;
	localparam logic [REQ_BITS-1:0] REQ_NOP_7 = 3'd7;

	typedef struct {
		req_t beat;
		bit   drain; // hold off until every result is back
	} backlog_t;

	logic clk;
	logic arst_n = 1'b0;
	logic start  = 1'b0;
	logic busy;
	logic done;
	req_t req    = '0;
	rsp_t rsp;

	ring_buffer_deque_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.req    (req),
		.done   (done),
		.rsp    (rsp)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// shadow of the deque contents
	logic signed [VALUE_BITS-1:0] shadow_words [DEPTH];
	int shadow_head = 0;
	int shadow_tail = 0;
	int shadow_fill = 0;

	backlog_t req_backlog[$];
	rsp_t     deque_rsp_q[$];

	int  cycle_cnt    = 0;
	int  mismatches   = 0;
	int  n_beats      = 0;
	int  n_results    = 0;
	int  n_full_rej   = 0;
	int  n_empty_rej  = 0;
	int  n_clears     = 0;
	int  idle_left    = 0;
	bit  burst_mode   = 1'b0;

	function automatic rsp_t deque_predict(req_t r);
		rsp_t o;
		o = '0;
		o.status = ST_OK;
		case (r.req_type)
			REQ_PUSH_BACK: begin
				if (shadow_fill == DEPTH) o.status = ST_FULL;
				else begin
					shadow_words[shadow_tail] = r.push_value;
					shadow_tail = (shadow_tail + 1) % DEPTH;
					shadow_fill++;
				end
			end
			REQ_PUSH_FRONT: begin
				if (shadow_fill == DEPTH) o.status = ST_FULL;
				else begin
					shadow_head = (shadow_head + DEPTH - 1) % DEPTH;
					shadow_words[shadow_head] = r.push_value;
					shadow_fill++;
				end
			end
			REQ_POP_FRONT: begin
				if (shadow_fill == 0) o.status = ST_EMPTY;
				else begin
					o.result_value = shadow_words[shadow_head];
					shadow_head = (shadow_head + 1) % DEPTH;
					shadow_fill--;
				end
			end
			REQ_POP_BACK: begin
				if (shadow_fill == 0) o.status = ST_EMPTY;
				else begin
					shadow_tail = (shadow_tail + DEPTH - 1) % DEPTH;
					o.result_value = shadow_words[shadow_tail];
					shadow_fill--;
				end
			end
			REQ_PEEK_FRONT: begin
				if (shadow_fill == 0) o.status = ST_EMPTY;
				else o.result_value = shadow_words[shadow_head];
			end
			REQ_CLEAR: begin
				shadow_head = 0;
				shadow_tail = 0;
				shadow_fill = 0;
			end
			default: ;
		endcase
		o.item_count = ITEM_CNT_BITS'(shadow_fill);
		return o;
	endfunction

	function automatic logic signed [VALUE_BITS-1:0] draw_word();
		case ($urandom_range(0, 11))
			0: return 32'sh7FFF_FFFF;
			1: return 32'sh8000_0000;
			2: return '0;
			3: return '1;
			default: return $urandom;
		endcase
	endfunction

	// bias: 0 push-heavy, 1 pop-heavy, 2 balanced
	function automatic req_t draw_req(int bias);
		req_t r;
		int   p;
		int   push_pct;
		r.push_value = draw_word();
		p = $urandom_range(0, 99);
		push_pct = (bias == 0) ? 80 : (bias == 1) ? 20 : 50;
		if (p < 2) r.req_type = REQ_CLEAR;
		else if (p < 4) r.req_type = $urandom_range(0, 1) ? REQ_NOP_7 : REQ_NOP_6;
		else if ($urandom_range(0, 99) < push_pct)
			r.req_type = $urandom_range(0, 1) ? REQ_PUSH_FRONT : REQ_PUSH_BACK;
		else begin
			case ($urandom_range(0, 4))
				0, 1: r.req_type = REQ_POP_FRONT;
				2, 3: r.req_type = REQ_POP_BACK;
				default: r.req_type = REQ_PEEK_FRONT;
			endcase
		end
		return r;
	endfunction

	task automatic queue_beat(logic [REQ_BITS-1:0] code, logic signed [VALUE_BITS-1:0] v);
		backlog_t b;
		b.beat.req_type   = code;
		b.beat.push_value = v;
		b.drain           = 1'b0;
		req_backlog.push_back(b);
	endtask

	task automatic queue_drain();
		backlog_t b;
		b.beat  = '0;
		b.drain = 1'b1;
		req_backlog.push_back(b);
	endtask

	always @(posedge clk) cycle_cnt <= cycle_cnt + 1;

	initial begin
		wait (cycle_cnt >= CYCLE_LIMIT);
		$display("timeout after %0d cycles, %0d results pending", cycle_cnt, deque_rsp_q.size());
		$display("== FAIL ==");
		$finish;
	end

	// request driver
	always @(posedge clk) begin : drive_beats
		logic     fire;
		logic     nxt_start;
		req_t     nxt_req;
		backlog_t head;
		if (arst_n) begin
			fire      = start && !busy;
			nxt_start = start && !fire;
			nxt_req   = req;
			if (fire) begin
				rsp_t e;
				e = deque_predict(req);
				deque_rsp_q.push_back(e);
				n_beats++;
				if (e.status == ST_FULL) n_full_rej++;
				if (e.status == ST_EMPTY) n_empty_rej++;
				if (req.req_type == REQ_CLEAR) n_clears++;
				idle_left = burst_mode ? 0 : $urandom_range(0, 3);
				if ($urandom_range(0, 49) == 0) burst_mode = !burst_mode;
			end
			if (!nxt_start) begin
				if (idle_left > 0) idle_left--;
				else if (req_backlog.size() > 0) begin
					if (req_backlog[0].drain) begin
						if (deque_rsp_q.size() == 0) void'(req_backlog.pop_front());
					end else begin
						head      = req_backlog.pop_front();
						nxt_req   = head.beat;
						nxt_start = 1'b1;
					end
				end
			end
			start <= nxt_start;
			req   <= nxt_req;
		end
	end

	// result checker
	always @(posedge clk) begin : check_results
		rsp_t want;
		if (arst_n && done === 1'b1) begin
			n_results++;
			if (deque_rsp_q.size() == 0) begin
				$error("result beat with no request outstanding");
				mismatches++;
			end else begin
				want = deque_rsp_q.pop_front();
				if (rsp.result_value !== want.result_value) begin
					$error("result_value: expected %0d, got %0d",
						want.result_value, rsp.result_value);
					mismatches++;
				end
				if (rsp.status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, rsp.status);
					mismatches++;
				end
				if (rsp.item_count !== want.item_count) begin
					$error("item_count: expected %0d, got %0d",
						want.item_count, rsp.item_count);
					mismatches++;
				end
			end
		end
	end

	initial begin
		int   bias;
		req_t rnd_req;
		for (int i = 0; i < DEPTH; i++) shadow_words[i] = '0;

		// empty-queue rejects and an undefined code
		queue_beat(REQ_POP_FRONT, 32'sd5);
		queue_beat(REQ_POP_BACK, -32'sd5);
		queue_beat(REQ_PEEK_FRONT, '1);
		queue_beat(REQ_NOP_6, 32'sh7FFF_FFFF);
		// fill from both ends, then push into a full queue
		for (int i = 0; i < DEPTH; i++) begin
			queue_beat((i % 2) ? REQ_PUSH_FRONT : REQ_PUSH_BACK,
				(i == 0) ? 32'sh7FFF_FFFF : (i == 1) ? 32'sh8000_0000 :
				(i == 2) ? -32'sd1 : (i == 3) ? 32'sd0 : draw_word());
		end
		queue_beat(REQ_PUSH_BACK, 32'sh1234_5678);
		queue_beat(REQ_PUSH_FRONT, 32'sh8765_4321);
		queue_beat(REQ_NOP_7, '1);
		queue_beat(REQ_PEEK_FRONT, '0);
		queue_beat(REQ_POP_BACK, '0);
		queue_beat(REQ_POP_FRONT, '0);
		queue_beat(REQ_CLEAR, 32'sh5555_5555);
		queue_beat(REQ_POP_FRONT, '0);
		queue_drain();

		bias = 2;
		for (int i = 0; i < N_RANDOM; i++) begin
			if (i % 40 == 0) bias = $urandom_range(0, 2);
			if (i % 450 == 449) queue_drain();
			rnd_req = draw_req(bias);
			queue_beat(rnd_req.req_type, rnd_req.push_value);
		end

		repeat (8) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		while (req_backlog.size() != 0 || start || deque_rsp_q.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		$display("%0d requests, %0d results checked, %0d mismatches", n_beats, n_results,
			mismatches);
		$display("rejects: %0d full, %0d empty; %0d clears", n_full_rej, n_empty_rej,
			n_clears);
		if (mismatches == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

FILE: sim.f
rtl/core/rbdq_pkg.sv
rtl/core/rbdq_ctrl.sv
rtl/core/rbdq_datapath.sv
rtl/core/ring_buffer_deque_core.sv
rtl/core/rbdq_checker.sv
tb/tb_top.sv
